[hw/rtl/length_field_packet_deframer_core_macros.svh]
// Assertion macros for the length-field packet deframer.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef LENGTH_FIELD_PACKET_DEFRAMER_CORE_MACROS_SVH
`define LENGTH_FIELD_PACKET_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LFPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LFPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lfpd_pkg.sv]
// Shared types and constants for the length-field packet deframer.
// No dependencies; used by lfpd_out_buf and the top level.
`default_nettype none

package lfpd_pkg;

  // Field and register widths.
  localparam int BYTE_W      = 8;
  localparam int INDEX_W     = 16;
  localparam int OFFSET_W    = 10;
  localparam int MAX_SIZE_W  = 16;
  localparam int LEN_WORD_W  = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Compare width: one bit above the length word, wide enough for counts up to the length word's width.
  localparam int CMP_W = LEN_WORD_W + 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_OFFSET   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PACKET_SIZE = 2'd1;

  // Register reset values.
  localparam logic [OFFSET_W-1:0]   OFFSET_RESET   = 10'd0;
  localparam logic [MAX_SIZE_W-1:0] MAX_SIZE_RESET = 16'd4096;

  // Input operation codes.
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_BAD_LENGTH = 1'b1;

  // One result word.
  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [INDEX_W-1:0] index;
    logic               last;
    logic               status;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/lfpd_out_buf.sv]
// Two-entry output buffer (result register plus skid register).
// Depends on lfpd_pkg for the result word type.
`default_nettype none

module lfpd_out_buf (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lfpd_pkg::result_t push_data,
  output logic                  full,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output lfpd_pkg::result_t     out_data
);

  logic              out_valid_r;
  logic              skid_valid_r;
  lfpd_pkg::result_t out_data_r;
  lfpd_pkg::result_t skid_data_r;
  logic              take;

  assign take      = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Control: the skid entry drains into the result register first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
      end
    end else if (!out_valid_r || take) begin
      if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/length_field_packet_deframer_core.sv]
// Length-field packet deframer, top level: framing state, checks, config registers.
// Depends on lfpd_pkg, lfpd_out_buf and length_field_packet_deframer_core_macros.svh.
//
// Takes one stream word per clock and passes each data byte on with its index in
// the packet; results are registered in the output buffer. The little-endian
// length word at length_offset is checked as its fourth byte arrives; a negative,
// too short, too long or uncountable length aborts the packet (status 1, last 1)
// and locks the stream until a restart word. Sustained rate is one word per cycle;
// the input stalls only while both output buffer entries hold results not yet taken.
// Configuration is to be written only while idle; the block does not enforce this.
`default_nettype none
`include "length_field_packet_deframer_core_macros.svh"

module length_field_packet_deframer_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lfpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [lfpd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_op,
  input  wire logic [lfpd_pkg::BYTE_W-1:0]        in_data_byte,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [lfpd_pkg::BYTE_W-1:0]             out_byte,
  output logic [lfpd_pkg::INDEX_W-1:0]            out_byte_index,
  output logic                                    out_last_of_packet,
  output logic                                    out_status
);

  localparam int CW = lfpd_pkg::CMP_W;
  localparam int LW = lfpd_pkg::LEN_WORD_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [CW-1:0] LEN_LIMIT = CW'(1) << COUNT_WIDTH;

  // Configuration registers.
  logic [lfpd_pkg::OFFSET_W-1:0]   length_offset_r;
  logic [lfpd_pkg::MAX_SIZE_W-1:0] max_packet_size_r;

  // Framing state.
  logic [COUNT_WIDTH-1:0] byte_count_r;
  logic [LW-1:0]          length_word_r;
  logic                   length_known_r;
  logic                   error_lock_r;

  logic              item_acc;
  logic              res_push;
  logic              buf_full;
  logic [CW-1:0]     idx_ext;
  logic [CW-1:0]     off_ext;
  logic [CW-1:0]     diff;
  logic              in_window;
  logic [1:0]        pos;
  logic [LW-1:0]     word_merged;
  logic [CW-1:0]     word_ext;
  logic              word_done;
  logic              len_bad;
  logic              bad;
  logic              known_nxt;
  logic [LW-1:0]     word_nxt;
  logic              last;
  lfpd_pkg::result_t res;
  lfpd_pkg::result_t out_data;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_offset_r   <= lfpd_pkg::OFFSET_RESET;
      max_packet_size_r <= lfpd_pkg::MAX_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lfpd_pkg::REG_LENGTH_OFFSET: begin
          length_offset_r <= cfg_data[lfpd_pkg::OFFSET_W-1:0];
        end
        lfpd_pkg::REG_MAX_PACKET_SIZE: begin
          max_packet_size_r <= cfg_data[lfpd_pkg::MAX_SIZE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Input handshake.
  assign in_stall = buf_full;
  assign item_acc = in_valid && !in_stall;
  assign res_push = item_acc && (in_op == lfpd_pkg::OP_DATA) && !error_lock_r;

  // Position of this byte relative to the length word.
  assign idx_ext   = CW'(byte_count_r);
  assign off_ext   = CW'(length_offset_r);
  assign diff      = idx_ext - off_ext;
  assign in_window = !length_known_r && (idx_ext >= off_ext) && (diff < CW'(4));
  assign pos       = diff[1:0];

  // Gather the length word and check it once its last byte is in.
  assign word_merged = length_word_r | (LW'(in_data_byte) << {pos, 3'b000});
  assign word_ext    = CW'(word_merged);
  assign word_done   = in_window && (pos == 2'd3);
  assign len_bad     = word_merged[LW-1] || (word_ext < off_ext + CW'(4)) ||
                       (word_ext > CW'(max_packet_size_r)) || (word_ext > LEN_LIMIT);
  assign bad         = word_done && len_bad;
  assign known_nxt   = length_known_r || (word_done && !len_bad);
  assign word_nxt    = in_window ? word_merged : length_word_r;
  assign last        = bad || (known_nxt && (idx_ext + CW'(1) == CW'(word_nxt)));

  // Framing state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= '0;
      length_word_r  <= '0;
      length_known_r <= 1'b0;
      error_lock_r   <= 1'b0;
    end else if (item_acc) begin
      if (in_op == lfpd_pkg::OP_RESTART) begin
        byte_count_r   <= '0;
        length_word_r  <= '0;
        length_known_r <= 1'b0;
        error_lock_r   <= 1'b0;
      end else if (!error_lock_r) begin
        if (bad) begin
          error_lock_r <= 1'b1;
        end else if (last) begin
          byte_count_r   <= '0;
          length_word_r  <= '0;
          length_known_r <= 1'b0;
        end else begin
          length_word_r  <= word_nxt;
          length_known_r <= known_nxt;
          if (byte_count_r != COUNT_MAX) begin
            byte_count_r <= byte_count_r + COUNT_WIDTH'(1);
          end
        end
      end
    end
  end

  // Result word for this byte.
  always_comb begin
    res.data   = in_data_byte;
    res.index  = lfpd_pkg::INDEX_W'(byte_count_r);
    res.last   = last;
    res.status = bad ? lfpd_pkg::STATUS_BAD_LENGTH : lfpd_pkg::STATUS_OK;
  end

  lfpd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_byte           = out_data.data;
  assign out_byte_index     = out_data.index;
  assign out_last_of_packet = out_data.last;
  assign out_status         = out_data.status;

  // An aborted packet always ends on the flagged byte.
  `LFPD_ASSERT_NOW(a_bad_is_last, out_valid && (out_status == lfpd_pkg::STATUS_BAD_LENGTH), out_last_of_packet, "illegal length word not marked last")

  // Once the length is known the count stays below it.
  `LFPD_ASSERT_NOW(a_count_below_len, length_known_r, CW'(byte_count_r) < CW'(length_word_r), "byte count ran past known packet length")

  // A flagged byte locks the stream.
  `LFPD_ASSERT_NEXT(a_bad_locks, res_push && bad, error_lock_r, "illegal length did not lock the stream")

endmodule

`default_nettype wire
